// File: rtl/pcp_pkg.sv
// ----------------------------------------------------------------------------
// pcp_pkg
// Shared types and character constants for the PETSCII to ANSI printer.
// ----------------------------------------------------------------------------
package pcp_pkg;

    // result buffer sizing
    localparam int unsigned MAX_RESULTS = 9;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

    // bus operation codes
    typedef enum logic [2:0] {
        OP_LISTEN    = 3'd0,
        OP_SECONDARY = 3'd1,
        OP_DATA      = 3'd2,
        OP_UNLISTEN  = 3'd3,
        OP_RESET     = 3'd4,
        OP_INIT      = 3'd5
    } t_op;

    // bus mode
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_LISTEN = 2'd1,
        MODE_OUTPUT = 2'd2
    } t_bus_mode;

    // configuration register indexes
    localparam logic REG_CONV_EN = 1'b0;
    localparam logic REG_DEV_NUM = 1'b1;

    // character codes
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_RVS_ON   = 8'd18;
    localparam logic [7:0] CH_RVS_OFF  = 8'd146;
    localparam logic [7:0] CH_QUOTE    = 8'd34;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_TILDE    = 8'd126;
    localparam logic [7:0] CH_NBSP     = 8'd160;
    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_LBRACKET = 8'd91;
    localparam logic [7:0] CH_SEVEN    = 8'd55;
    localparam logic [7:0] CH_ZERO     = 8'd48;
    localparam logic [7:0] CH_LOWER_M  = 8'd109;
    localparam logic [7:0] CH_UPPER_R  = 8'd82;
    localparam logic [7:0] CH_UNDER    = 8'd95;

    // printer state
    typedef struct packed {
        t_bus_mode bus_mode;
        logic      ready;
        logic      reverse_on;
        logic      quote_mode;
    } t_state;

    // byte run produced by one item
    typedef logic [MAX_RESULTS-1:0][7:0] t_byte_vec;

    typedef struct packed {
        t_byte_vec        bytes;
        logic [CNT_W-1:0] count;
    } t_seq;

endpackage

// File: rtl/pcp_convert.sv
// ----------------------------------------------------------------------------
// pcp_convert
// Decodes one bus item against the printer state: next state and byte run.
// ----------------------------------------------------------------------------
module pcp_convert (
    input  logic [2:0]      i_op,
    input  logic [4:0]      i_addr,
    input  logic [7:0]      i_data,
    input  logic            i_conv_en,
    input  logic [4:0]      i_dev_num,
    input  pcp_pkg::t_state i_state,
    output pcp_pkg::t_state o_state,
    output pcp_pkg::t_seq   o_seq
);

    logic is_ctrl;

    // non-printable codes
    assign is_ctrl = (i_data < pcp_pkg::CH_SPACE) ||
                     ((i_data > pcp_pkg::CH_TILDE) && (i_data < pcp_pkg::CH_NBSP));

    // operation decode and byte run build
    always_comb begin
        o_state     = i_state;
        o_seq.bytes = '0;
        o_seq.count = '0;
        case (pcp_pkg::t_op'(i_op))
            pcp_pkg::OP_LISTEN: begin
                if (i_state.ready && (i_addr == i_dev_num)) begin
                    o_state.bus_mode = pcp_pkg::MODE_LISTEN;
                end
            end
            pcp_pkg::OP_SECONDARY: begin
                if (i_state.bus_mode == pcp_pkg::MODE_LISTEN) begin
                    o_state.bus_mode = pcp_pkg::MODE_OUTPUT;
                end
            end
            pcp_pkg::OP_UNLISTEN: begin
                o_state.bus_mode = pcp_pkg::MODE_IDLE;
            end
            pcp_pkg::OP_RESET: begin
                o_state.ready    = 1'b1;
                o_state.bus_mode = pcp_pkg::MODE_IDLE;
            end
            pcp_pkg::OP_INIT: begin
                o_state.ready = 1'b1;
            end
            pcp_pkg::OP_DATA: begin
                if (i_state.bus_mode == pcp_pkg::MODE_OUTPUT) begin
                    if (!i_conv_en) begin
                        // raw pass-through
                        o_seq.bytes[0] = i_data;
                        o_seq.count    = pcp_pkg::CNT_W'(1);
                    end else if ((i_data == pcp_pkg::CH_LF) ||
                                 (i_data == pcp_pkg::CH_CR)) begin
                        // line end, drops quote and reverse
                        o_state.quote_mode = 1'b0;
                        o_seq.bytes[0]     = pcp_pkg::CH_LF;
                        o_seq.count        = pcp_pkg::CNT_W'(1);
                        if (i_state.reverse_on) begin
                            o_state.reverse_on = 1'b0;
                            o_seq.bytes[1]     = pcp_pkg::CH_ESC;
                            o_seq.bytes[2]     = pcp_pkg::CH_LBRACKET;
                            o_seq.bytes[3]     = pcp_pkg::CH_ZERO;
                            o_seq.bytes[4]     = pcp_pkg::CH_LOWER_M;
                            o_seq.count        = pcp_pkg::CNT_W'(5);
                        end
                    end else if ((i_data == pcp_pkg::CH_RVS_ON) ||
                                 (i_data == pcp_pkg::CH_RVS_OFF)) begin
                        if (!i_state.quote_mode) begin
                            // reverse switch as escape sequence
                            o_state.reverse_on = (i_data == pcp_pkg::CH_RVS_ON);
                            o_seq.bytes[0]     = pcp_pkg::CH_ESC;
                            o_seq.bytes[1]     = pcp_pkg::CH_LBRACKET;
                            o_seq.bytes[2]     = (i_data == pcp_pkg::CH_RVS_ON) ?
                                                 pcp_pkg::CH_SEVEN : pcp_pkg::CH_ZERO;
                            o_seq.bytes[3]     = pcp_pkg::CH_LOWER_M;
                            o_seq.count        = pcp_pkg::CNT_W'(4);
                        end else if (i_state.reverse_on) begin
                            // quoted reverse code, already reversed
                            o_seq.bytes[0] = (i_data == pcp_pkg::CH_RVS_ON) ?
                                             pcp_pkg::CH_UPPER_R : pcp_pkg::CH_UNDER;
                            o_seq.count    = pcp_pkg::CNT_W'(1);
                        end else begin
                            // quoted reverse code wrapped in reverse video
                            o_seq.bytes[0] = pcp_pkg::CH_ESC;
                            o_seq.bytes[1] = pcp_pkg::CH_LBRACKET;
                            o_seq.bytes[2] = pcp_pkg::CH_SEVEN;
                            o_seq.bytes[3] = pcp_pkg::CH_LOWER_M;
                            o_seq.bytes[4] = (i_data == pcp_pkg::CH_RVS_ON) ?
                                             pcp_pkg::CH_UPPER_R : pcp_pkg::CH_UNDER;
                            o_seq.bytes[5] = pcp_pkg::CH_ESC;
                            o_seq.bytes[6] = pcp_pkg::CH_LBRACKET;
                            o_seq.bytes[7] = pcp_pkg::CH_ZERO;
                            o_seq.bytes[8] = pcp_pkg::CH_LOWER_M;
                            o_seq.count    = pcp_pkg::CNT_W'(9);
                        end
                    end else if (i_data == pcp_pkg::CH_QUOTE) begin
                        o_state.quote_mode = ~i_state.quote_mode;
                        o_seq.bytes[0]     = pcp_pkg::CH_QUOTE;
                        o_seq.count        = pcp_pkg::CNT_W'(1);
                    end else if (is_ctrl) begin
                        o_seq.bytes[0] = pcp_pkg::CH_UNDER;
                        o_seq.count    = pcp_pkg::CNT_W'(1);
                    end else begin
                        o_seq.bytes[0] = i_data;
                        o_seq.count    = pcp_pkg::CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/pcp_emit.sv
// ----------------------------------------------------------------------------
// pcp_emit
// Result buffer: holds one byte run and shifts it out one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
module pcp_emit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  pcp_pkg::t_seq i_seq,
    output logic          o_free,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [7:0]    o_m_axis_tdata,   // [7:0] out_byte
    output logic          o_m_axis_tlast
);

    pcp_pkg::t_byte_vec           r_bytes;
    pcp_pkg::t_byte_vec           n_bytes;
    logic [pcp_pkg::CNT_W-1:0]    r_cnt;
    logic [pcp_pkg::CNT_W-1:0]    n_cnt;
    logic                         out_acc;

    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

    // buffer takes a new run once the last byte leaves
    assign o_free = (r_cnt == '0) ||
                    ((r_cnt == pcp_pkg::CNT_W'(1)) && i_m_axis_tready);

    // next buffer contents
    always_comb begin
        n_bytes = r_bytes;
        n_cnt   = r_cnt;
        if (i_load) begin
            n_bytes = i_seq.bytes;
            n_cnt   = i_seq.count;
        end else if (out_acc) begin
            n_bytes = {8'h00, r_bytes[pcp_pkg::MAX_RESULTS-1:1]};
            n_cnt   = r_cnt - pcp_pkg::CNT_W'(1);
        end
    end

    // count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // byte storage
    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
    end

    assign o_m_axis_tvalid = (r_cnt != '0);
    assign o_m_axis_tdata  = r_bytes[0];
    assign o_m_axis_tlast  = (r_cnt == pcp_pkg::CNT_W'(1));

endmodule

// File: rtl/petscii_printer_ansi_converter_top.sv
// Flow: an accepted item is held in the input register and decoded from it; its byte run is
// loaded into the result buffer once free, then sent one byte per cycle while the port is ready.
// Throughput: one item per cycle for items without output while the buffer is free; an item
// of n bytes (up to nine) holds the buffer until its last byte leaves: the output sets the rate.
// Reset (synchronous, active low): bus mode idle, not ready, reverse and quote off,
// conversion enabled, device number 4, no item or result pending.
// ----------------------------------------------------------------------------
// petscii_printer_ansi_converter_top
// Serial-bus printer front end converting PETSCII data bytes into ANSI text.
// ----------------------------------------------------------------------------
module petscii_printer_ansi_converter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [2:0] operation, [7:3] device_address,
                                          // [15:8] data_byte
    // result output
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast,   // last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic            r_in_valid;
    logic [2:0]      r_op;
    logic [4:0]      r_addr;
    logic [7:0]      r_data;
    logic            r_conv_en;
    logic [4:0]      r_dev_num;
    pcp_pkg::t_state r_state;
    pcp_pkg::t_state n_state;
    pcp_pkg::t_seq   conv_seq;
    logic            buf_free;
    logic            proc;
    logic            in_acc;
    logic            cfg_wr;

    // input register handshake
    assign proc            = r_in_valid && buf_free;
    assign o_s_axis_tready = !r_in_valid || proc;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op   <= i_s_axis_tdata[2:0];
            r_addr <= i_s_axis_tdata[7:3];
            r_data <= i_s_axis_tdata[15:8];
        end
    end

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conv_en <= 1'b1;
            r_dev_num <= 5'd4;
        end else if (cfg_wr) begin
            case (paddr[2])
                pcp_pkg::REG_CONV_EN: r_conv_en <= pwdata[0];
                pcp_pkg::REG_DEV_NUM: r_dev_num <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (paddr[2])
            pcp_pkg::REG_CONV_EN: prdata = {31'd0, r_conv_en};
            pcp_pkg::REG_DEV_NUM: prdata = {27'd0, r_dev_num};
            default:              prdata = '0;
        endcase
    end

    // item decode
    pcp_convert u_convert (
        .i_op      (r_op),
        .i_addr    (r_addr),
        .i_data    (r_data),
        .i_conv_en (r_conv_en),
        .i_dev_num (r_dev_num),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_seq     (conv_seq)
    );

    // printer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.bus_mode   <= pcp_pkg::MODE_IDLE;
            r_state.ready      <= 1'b0;
            r_state.reverse_on <= 1'b0;
            r_state.quote_mode <= 1'b0;
        end else if (proc) begin
            r_state <= n_state;
        end
    end

    // result buffer
    pcp_emit u_emit (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (proc),
        .i_seq           (conv_seq),
        .o_free          (buf_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
